// ===== rtl/tlrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types, codes and constants for the three-level ready queue.
// ----------------------------------------------------------------------------
package tlrq_pkg;

    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int BURST_BITS_DEF  = 16;

    localparam int FUNC_W        = 2;
    localparam int ID_W          = 8;
    localparam int PRIO_W        = 8;
    localparam int FIELD_BURST_W = 16;
    localparam int LVL_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_W         = 8;

    localparam logic [CFG_W-1:0] TOP_FLOOR_RST = 8'd100;
    localparam logic [CFG_W-1:0] MID_FLOOR_RST = 8'd50;
    localparam logic [CFG_W-1:0] PRIO_CEIL_RST = 8'd149;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_CEIL = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_PICK   = 2'd1,
        FUNC_CHECK  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_PRIO = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [LVL_W-1:0] {
        LVL_NONE = 2'd0,
        LVL_TOP  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_LOW  = 2'd3
    } t_level;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [ID_W-1:0]          task_id;
        logic [PRIO_W-1:0]        task_priority;
        logic [FIELD_BURST_W-1:0] burst_estimate;
        logic [FIELD_BURST_W-1:0] burst_used;
        logic [FIELD_BURST_W-1:0] running_estimate;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]     picked_id;
        logic [LVL_W-1:0]    picked_level;
        logic                should_preempt;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic decode;
        logic walk;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic need_walk;
        logic walk_done;
    } t_dp_stat;

endpackage

// ===== rtl/tlrq_chan_if.sv =====
// ----------------------------------------------------------------------------
// tlrq_chan_if
// Valid/ready channel carrying one item of type T_DATA.
// ----------------------------------------------------------------------------
interface tlrq_chan_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tlrq_ram.sv =====
// ----------------------------------------------------------------------------
// tlrq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tlrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlrq_ctrl
// Sequencer: accept, decode, table walk, result hand-off.
// ----------------------------------------------------------------------------
module tlrq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output tlrq_pkg::t_dp_cmd  o_cmd,
    input  tlrq_pkg::t_dp_stat i_stat
);
    import tlrq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_WALK   = 4'b0100,
        S_PUSH   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_stat.need_walk ? S_WALK : S_PUSH;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
endmodule

// ===== rtl/tlrq_dpath.sv =====
// ----------------------------------------------------------------------------
// tlrq_dpath
// Level tables, counts, ring pointers, band registers and result registers.
// ----------------------------------------------------------------------------
module tlrq_dpath #(
    parameter int LEVEL_DEPTH = tlrq_pkg::LEVEL_DEPTH_DEF,
    parameter int BURST_BITS  = tlrq_pkg::BURST_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlrq_pkg::t_dp_cmd  i_cmd,
    output tlrq_pkg::t_dp_stat o_stat,
    input  tlrq_pkg::t_req     i_req_data,
    input  logic               i_cfg_valid,
    input  tlrq_pkg::t_cfg     i_cfg_data,
    output tlrq_pkg::t_rsp     o_rsp_data
);
    import tlrq_pkg::*;

    localparam int IDX_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int COUNT_W = $clog2(LEVEL_DEPTH + 1);
    localparam int REM_W   = BURST_BITS + 1;
    localparam int TOP_W   = ID_W + BURST_BITS + REM_W;
    localparam int MID_W   = ID_W + PRIO_W;
    localparam int EXT_W   = FIELD_BURST_W + 32;

    localparam logic [COUNT_W-1:0] CNT_ONE  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] CNT_TWO  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] CNT_FULL = COUNT_W'(LEVEL_DEPTH);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(LEVEL_DEPTH - 1);

    // band registers
    logic [CFG_W-1:0] r_top_floor, r_mid_floor, r_prio_ceil;

    // level bookkeeping
    logic [COUNT_W-1:0] r_cnt_top, r_cnt_mid, r_cnt_low;
    logic [COUNT_W-1:0] n_cnt_top, n_cnt_mid, n_cnt_low;
    logic [IDX_W-1:0]   r_head, r_tail, n_head, n_tail;

    // latched item
    t_func              r_func;
    logic [ID_W-1:0]    r_id;
    logic [PRIO_W-1:0]  r_prio;
    logic [BURST_BITS-1:0] r_est, r_used, r_run;
    logic [EXT_W-1:0]   ext_est, ext_used, ext_run;

    // walk state
    t_level             r_lvl, n_lvl;
    logic [COUNT_W-1:0] r_pos, n_pos;
    logic               r_placing, n_placing;
    t_rsp               r_res, n_res, r_rsp;

    // decode
    logic [REM_W-1:0]   rem;
    t_level             ins_lvl, pick_lvl, dec_lvl, act_lvl;
    logic               prio_bad;
    logic [COUNT_W-1:0] cnt_dec, cnt_cur;
    logic               inc_cnt, dec_cnt, shift;

    // table ports
    logic               wr_en, wr_new;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic               top_we, mid_we, low_we;
    logic [TOP_W-1:0]   top_wdata, top_rdata, top_new;
    logic [MID_W-1:0]   mid_wdata, mid_rdata, mid_new;
    logic [ID_W-1:0]    low_rdata;
    logic [ID_W-1:0]    top_rd_id, mid_rd_id;
    logic [BURST_BITS-1:0] top_rd_est;
    logic [REM_W-1:0]   top_rd_rem;
    logic [PRIO_W-1:0]  mid_rd_prio;

    assign ext_est  = {32'd0, i_req_data.burst_estimate};
    assign ext_used = {32'd0, i_req_data.burst_used};
    assign ext_run  = {32'd0, i_req_data.running_estimate};

    assign rem     = {1'b0, r_est} - {1'b0, r_used};
    assign top_new = {r_id, r_est, rem};
    assign mid_new = {r_id, r_prio};

    assign top_rd_id   = top_rdata[TOP_W-1 -: ID_W];
    assign top_rd_est  = top_rdata[REM_W +: BURST_BITS];
    assign top_rd_rem  = top_rdata[REM_W-1:0];
    assign mid_rd_id   = mid_rdata[MID_W-1 -: ID_W];
    assign mid_rd_prio = mid_rdata[PRIO_W-1:0];

    always_comb begin
        prio_bad = (r_prio > r_prio_ceil);
        if (prio_bad) begin
            ins_lvl = LVL_NONE;
        end else if (r_prio >= r_top_floor) begin
            ins_lvl = LVL_TOP;
        end else if (r_prio >= r_mid_floor) begin
            ins_lvl = LVL_MID;
        end else begin
            ins_lvl = LVL_LOW;
        end

        if (r_cnt_top != '0) begin
            pick_lvl = LVL_TOP;
        end else if (r_cnt_mid != '0) begin
            pick_lvl = LVL_MID;
        end else if (r_cnt_low != '0) begin
            pick_lvl = LVL_LOW;
        end else begin
            pick_lvl = LVL_NONE;
        end

        dec_lvl = (r_func == FUNC_INSERT) ? ins_lvl : pick_lvl;
        act_lvl = i_cmd.decode ? dec_lvl : r_lvl;
    end

    always_comb begin
        case (dec_lvl)
            LVL_TOP: cnt_dec = r_cnt_top;
            LVL_MID: cnt_dec = r_cnt_mid;
            LVL_LOW: cnt_dec = r_cnt_low;
            default: cnt_dec = '0;
        endcase
        case (r_lvl)
            LVL_TOP: cnt_cur = r_cnt_top;
            LVL_MID: cnt_cur = r_cnt_mid;
            LVL_LOW: cnt_cur = r_cnt_low;
            default: cnt_cur = '0;
        endcase
        if (r_lvl == LVL_TOP) begin
            shift = ($signed(top_rd_rem) > $signed(rem));
        end else begin
            shift = (mid_rd_prio < r_prio);
        end
    end

    always_comb begin
        o_stat.need_walk = 1'b0;
        case (r_func)
            FUNC_INSERT: o_stat.need_walk = (ins_lvl == LVL_TOP || ins_lvl == LVL_MID)
                                            && (cnt_dec != '0) && (cnt_dec < CNT_FULL);
            FUNC_PICK:   o_stat.need_walk = (pick_lvl != LVL_NONE);
            FUNC_CHECK:  o_stat.need_walk = (r_cnt_top != '0);
            default:     o_stat.need_walk = 1'b0;
        endcase

        o_stat.walk_done = 1'b1;
        case (r_func)
            FUNC_INSERT: o_stat.walk_done = r_placing || !shift;
            FUNC_PICK:   o_stat.walk_done = (r_lvl == LVL_LOW) || (r_pos == cnt_cur - CNT_ONE);
            default:     o_stat.walk_done = 1'b1;
        endcase
    end

    always_comb begin
        n_res     = r_res;
        n_lvl     = r_lvl;
        n_pos     = r_pos;
        n_placing = r_placing;
        n_head    = r_head;
        n_tail    = r_tail;
        inc_cnt   = 1'b0;
        dec_cnt   = 1'b0;
        wr_en     = 1'b0;
        wr_new    = 1'b0;
        wr_addr   = '0;
        rd_addr   = '0;
        low_we    = 1'b0;

        if (i_cmd.decode) begin
            n_res     = '0;
            n_lvl     = dec_lvl;
            n_placing = 1'b0;
            case (r_func)
                FUNC_INSERT: begin
                    if (prio_bad) begin
                        n_res.status = ST_BAD_PRIO;
                    end else if (cnt_dec >= CNT_FULL) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_res.picked_level = dec_lvl;
                        if (dec_lvl == LVL_LOW) begin
                            low_we  = 1'b1;
                            n_tail  = (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
                            inc_cnt = 1'b1;
                        end else if (cnt_dec == '0) begin
                            wr_en   = 1'b1;
                            wr_new  = 1'b1;
                            inc_cnt = 1'b1;
                        end else begin
                            n_pos   = cnt_dec;
                            rd_addr = IDX_W'(cnt_dec - CNT_ONE);
                        end
                    end
                end
                FUNC_PICK: begin
                    n_pos              = '0;
                    n_res.picked_level = dec_lvl;
                    if (dec_lvl == LVL_NONE) begin
                        n_res.status = ST_EMPTY;
                    end
                end
                FUNC_CHECK: begin
                    n_lvl = LVL_TOP;
                end
                default: n_lvl = LVL_NONE;
            endcase
        end

        if (i_cmd.walk) begin
            case (r_func)
                FUNC_CHECK: begin
                    n_res.should_preempt = (top_rd_est < r_run);
                end
                FUNC_PICK: begin
                    if (r_lvl == LVL_LOW) begin
                        n_res.picked_id = low_rdata;
                        n_head  = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
                        dec_cnt = 1'b1;
                    end else begin
                        if (r_pos == '0) begin
                            n_res.picked_id = (r_lvl == LVL_TOP) ? top_rd_id : mid_rd_id;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = IDX_W'(r_pos - CNT_ONE);
                        end
                        if (r_pos == cnt_cur - CNT_ONE) begin
                            dec_cnt = 1'b1;
                        end else begin
                            n_pos   = r_pos + CNT_ONE;
                            rd_addr = IDX_W'(r_pos + CNT_ONE);
                        end
                    end
                end
                FUNC_INSERT: begin
                    if (r_placing || !shift) begin
                        wr_en   = 1'b1;
                        wr_new  = 1'b1;
                        wr_addr = IDX_W'(r_pos);
                        inc_cnt = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(r_pos);
                        n_pos   = r_pos - CNT_ONE;
                        if (r_pos == CNT_ONE) begin
                            n_placing = 1'b1;
                        end else begin
                            rd_addr = IDX_W'(r_pos - CNT_TWO);
                        end
                    end
                end
                default: n_res = r_res;
            endcase
        end
    end

    always_comb begin
        top_we    = wr_en && (act_lvl == LVL_TOP);
        mid_we    = wr_en && (act_lvl == LVL_MID);
        top_wdata = wr_new ? top_new : top_rdata;
        mid_wdata = wr_new ? mid_new : mid_rdata;

        n_cnt_top = r_cnt_top;
        n_cnt_mid = r_cnt_mid;
        n_cnt_low = r_cnt_low;
        case (act_lvl)
            LVL_TOP: n_cnt_top = r_cnt_top + (inc_cnt ? CNT_ONE : '0) - (dec_cnt ? CNT_ONE : '0);
            LVL_MID: n_cnt_mid = r_cnt_mid + (inc_cnt ? CNT_ONE : '0) - (dec_cnt ? CNT_ONE : '0);
            LVL_LOW: n_cnt_low = r_cnt_low + (inc_cnt ? CNT_ONE : '0) - (dec_cnt ? CNT_ONE : '0);
            default: n_cnt_top = r_cnt_top;
        endcase
    end

    tlrq_ram #(.WIDTH(TOP_W), .DEPTH(LEVEL_DEPTH)) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (top_we),
        .i_waddr (wr_addr),
        .i_wdata (top_wdata),
        .i_raddr (rd_addr),
        .o_rdata (top_rdata)
    );

    tlrq_ram #(.WIDTH(MID_W), .DEPTH(LEVEL_DEPTH)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (wr_addr),
        .i_wdata (mid_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mid_rdata)
    );

    tlrq_ram #(.WIDTH(ID_W), .DEPTH(LEVEL_DEPTH)) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (low_we),
        .i_waddr (r_tail),
        .i_wdata (r_id),
        .i_raddr (r_head),
        .o_rdata (low_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_floor <= TOP_FLOOR_RST;
            r_mid_floor <= MID_FLOOR_RST;
            r_prio_ceil <= PRIO_CEIL_RST;
            r_cnt_top   <= '0;
            r_cnt_mid   <= '0;
            r_cnt_low   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_lvl       <= LVL_NONE;
            r_pos       <= '0;
            r_placing   <= 1'b0;
            r_func      <= FUNC_NOP;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_data.index)
                    CFG_TOP_FLOOR: r_top_floor <= i_cfg_data.value;
                    CFG_MID_FLOOR: r_mid_floor <= i_cfg_data.value;
                    CFG_PRIO_CEIL: r_prio_ceil <= i_cfg_data.value;
                    default:       r_prio_ceil <= r_prio_ceil;
                endcase
            end
            r_cnt_top <= n_cnt_top;
            r_cnt_mid <= n_cnt_mid;
            r_cnt_low <= n_cnt_low;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_lvl     <= n_lvl;
            r_pos     <= n_pos;
            r_placing <= n_placing;
            if (i_cmd.load) begin
                r_func <= t_func'(i_req_data.func);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id   <= i_req_data.task_id;
            r_prio <= i_req_data.task_priority;
            r_est  <= ext_est[BURST_BITS-1:0];
            r_used <= ext_used[BURST_BITS-1:0];
            r_run  <= ext_run[BURST_BITS-1:0];
        end
        r_res <= n_res;
        if (i_cmd.push) begin
            r_rsp <= r_res;
        end
    end

    assign o_rsp_data = r_rsp;
endmodule

// ===== rtl/three_level_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// three_level_ready_queue_unit
// Three-level ready queue: sorted top level, priority-ordered middle level,
// FIFO low level, with pick and preemption check.
// ----------------------------------------------------------------------------
// From accept, an item passes the decode state, the table walk if needed,
// and the push state. Walk: insert into top/middle moves each entry behind
// the insert point down a slot, then writes the new one; a pick from the
// top or middle level takes the head and moves the rest up; a low pick
// reads the FIFO head; the check compares top head and running estimates.
// One item at a time; the push waits until the previous result is taken.
// Reset (synchronous): counts, ring pointers, band registers 100/50/149.
module three_level_ready_queue_unit #(
    parameter int LEVEL_DEPTH = tlrq_pkg::LEVEL_DEPTH_DEF,
    parameter int BURST_BITS  = tlrq_pkg::BURST_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlrq_chan_if.sink   i_req,
    tlrq_chan_if.source o_rsp,
    tlrq_chan_if.sink   i_cfg
);
    import tlrq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    tlrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    tlrq_dpath #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .BURST_BITS  (BURST_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req_data  (i_req.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_rsp_data  (o_rsp.data)
    );
endmodule
